// ===== rtl/ntcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ntcs_pkg: shared constants for the nearest tetrahedron centroid search
// request op codes, fixed field widths and parameter defaults
// ----------------------------------------------------------------------------
package ntcs_pkg;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 12;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int COORD_BITS_DEF   = 24;

endpackage

// ===== rtl/nearest_tetra_centroid_search.sv =====
// ----------------------------------------------------------------------------
// nearest_tetra_centroid_search: brute force nearest element centroid search
// vertex requests build per-axis element sums in a table memory; a query
// scans the table, one element per cycle, for the least 16x squared distance
// ----------------------------------------------------------------------------
// clear and add vertex requests: no result
// query: scan, drain of the distance pipeline, then the result register; an empty table skips the scan;
// the scan rate is set by one read per cycle from the element sum memory
// a query holds s_ready low until its result is loaded into the output register
// aresetn (synchronous) clears count, phase, partial sums and the overflow flag;
// the element memory is not cleared, entries are read only once written
module nearest_tetra_centroid_search #(
    parameter int MAX_ELEMENTS = ntcs_pkg::MAX_ELEMENTS_DEF,
    parameter int COORD_BITS   = ntcs_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ntcs_pkg::OP_W-1:0]     s_op,
    input  logic signed [COORD_BITS-1:0]  s_point_x,
    input  logic signed [COORD_BITS-1:0]  s_point_y,
    input  logic signed [COORD_BITS-1:0]  s_point_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ntcs_pkg::INDEX_W-1:0]  m_nearest_index,
    output logic                          m_table_empty,
    output logic                          m_table_overflow
);

    localparam int SUMW  = COORD_BITS + 2;
    localparam int PW    = COORD_BITS + 2;
    localparam int DW    = COORD_BITS + 3;
    localparam int SQW   = 2 * DW;
    localparam int DISTW = SQW + 2;
    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int WORDW = 3 * SUMW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic signed [SUMW-1:0] partial_x_reg, partial_x_next;
    logic signed [SUMW-1:0] partial_y_reg, partial_y_next;
    logic signed [SUMW-1:0] partial_z_reg, partial_z_next;
    logic [1:0]             phase_reg, phase_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   overflow_reg, overflow_next;

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic                         q_empty_reg, q_overflow_reg;
    logic [IDX_W-1:0]             scan_idx_reg, scan_idx_next;

    logic [WORDW-1:0] table_mem [MAX_ELEMENTS];
    logic [WORDW-1:0] rd_data_reg;
    logic             wr_en;
    logic [WORDW-1:0] wr_data;
    logic             rd_en;

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0] i1_reg, i2_reg, i3_reg, i4_reg;
    logic [DW-1:0]    ax_reg, ay_reg, az_reg;
    logic [SQW-1:0]   sx_reg, sy_reg, sz_reg;
    logic [DISTW-1:0] dist_reg;
    logic [DISTW-1:0] best_dist_reg;
    logic [IDX_W-1:0] best_idx_reg;

    logic                         m_valid_reg;
    logic [ntcs_pkg::INDEX_W-1:0] m_index_reg;
    logic                         m_empty_reg, m_overflow_reg;

    logic                   accept;
    logic                   table_full;
    logic                   scan_last;
    logic                   out_free;
    logic signed [SUMW-1:0] sum_x_new, sum_y_new, sum_z_new;
    logic signed [SUMW-1:0] rd_sx, rd_sy, rd_sz;
    logic signed [PW-1:0]   px4, py4, pz4;
    logic signed [DW-1:0]   dx, dy, dz;

    assign s_ready          = (state_reg == ST_IDLE);
    assign accept           = s_valid && s_ready;
    assign table_full       = (count_reg >= CNT_W'(MAX_ELEMENTS));
    assign scan_last        = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free         = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_nearest_index  = m_index_reg;
    assign m_table_empty    = m_empty_reg;
    assign m_table_overflow = m_overflow_reg;

    assign sum_x_new = partial_x_reg + SUMW'(s_point_x);
    assign sum_y_new = partial_y_reg + SUMW'(s_point_y);
    assign sum_z_new = partial_z_reg + SUMW'(s_point_z);

    assign wr_en   = accept && (s_op == ntcs_pkg::OP_ADD) && !table_full && (phase_reg == 2'd3);
    assign wr_data = {sum_z_new, sum_y_new, sum_x_new};
    assign rd_en   = (state_reg == ST_SCAN);

    // control and table build state
    always_comb begin
        state_next     = state_reg;
        partial_x_next = partial_x_reg;
        partial_y_next = partial_y_reg;
        partial_z_next = partial_z_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        scan_idx_next  = scan_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        ntcs_pkg::OP_CLEAR: begin
                            partial_x_next = '0;
                            partial_y_next = '0;
                            partial_z_next = '0;
                            phase_next     = '0;
                            count_next     = '0;
                            overflow_next  = 1'b0;
                        end
                        ntcs_pkg::OP_ADD: begin
                            if (table_full) begin
                                overflow_next = 1'b1;
                            end else if (phase_reg == 2'd3) begin
                                partial_x_next = '0;
                                partial_y_next = '0;
                                partial_z_next = '0;
                                phase_next     = '0;
                                count_next     = count_reg + CNT_W'(1);
                            end else begin
                                partial_x_next = sum_x_new;
                                partial_y_next = sum_y_new;
                                partial_z_next = sum_z_new;
                                phase_next     = phase_reg + 2'd1;
                            end
                        end
                        ntcs_pkg::OP_QUERY: begin
                            scan_idx_next = '0;
                            state_next    = (count_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg && !v3_reg && !v4_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            partial_x_reg <= '0;
            partial_y_reg <= '0;
            partial_z_reg <= '0;
            phase_reg     <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            scan_idx_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            partial_x_reg <= partial_x_next;
            partial_y_reg <= partial_y_next;
            partial_z_reg <= partial_z_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            scan_idx_reg  <= scan_idx_next;
        end
    end

    // query snapshot
    always_ff @(posedge aclk) begin
        if (accept && (s_op == ntcs_pkg::OP_QUERY)) begin
            qx_reg         <= s_point_x;
            qy_reg         <= s_point_y;
            qz_reg         <= s_point_z;
            q_empty_reg    <= (count_reg == '0);
            q_overflow_reg <= overflow_reg;
        end
    end

    // element sum memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[scan_idx_reg];
        end
    end

    // distance pipeline
    assign rd_sx = rd_data_reg[SUMW-1:0];
    assign rd_sy = rd_data_reg[2*SUMW-1:SUMW];
    assign rd_sz = rd_data_reg[3*SUMW-1:2*SUMW];
    assign px4   = {qx_reg, 2'b00};
    assign py4   = {qy_reg, 2'b00};
    assign pz4   = {qz_reg, 2'b00};
    assign dx    = DW'(px4) - DW'(rd_sx);
    assign dy    = DW'(py4) - DW'(rd_sy);
    assign dz    = DW'(pz4) - DW'(rd_sz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        i1_reg   <= scan_idx_reg;
        i2_reg   <= i1_reg;
        i3_reg   <= i2_reg;
        i4_reg   <= i3_reg;
        ax_reg   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay_reg   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
        az_reg   <= dz[DW-1] ? DW'(-dz) : DW'(dz);
        sx_reg   <= ax_reg * ax_reg;
        sy_reg   <= ay_reg * ay_reg;
        sz_reg   <= az_reg * az_reg;
        dist_reg <= DISTW'(sx_reg) + DISTW'(sy_reg) + DISTW'(sz_reg);
    end

    // running minimum, lowest index kept on ties
    always_ff @(posedge aclk) begin
        if (accept && (s_op == ntcs_pkg::OP_QUERY)) begin
            best_idx_reg <= '0;
        end else if (v4_reg && ((i4_reg == '0) || (dist_reg < best_dist_reg))) begin
            best_idx_reg  <= i4_reg;
            best_dist_reg <= dist_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_index_reg    <= ntcs_pkg::INDEX_W'(best_idx_reg);
            m_empty_reg    <= q_empty_reg;
            m_overflow_reg <= q_overflow_reg;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond table capacity");

    a_write_clears_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (phase_reg == '0) && (partial_x_reg == '0) && (count_reg != '0))
        else $error("element store did not restart the partial element");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !wr_en && !accept)
        else $error("table written or request taken during a query");

    a_query_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == ntcs_pkg::OP_QUERY) && (count_reg != '0)) |=>
        (state_reg == ST_SCAN) && (scan_idx_reg == '0))
        else $error("query did not start its scan at element zero");

    a_empty_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_empty_reg) |-> (m_index_reg == '0))
        else $error("empty table answered a nonzero index");

endmodule
